FILE: rtl/hce_pkg.sv
package hce_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned ModeW = 2;
  localparam int unsigned TotalW = 6;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [TotalW-1:0] TotalReset = 6'd38;
  localparam logic [2:0] HdrBase = 3'd4;
  localparam logic [3:0] HexMask = 4'hf;

  localparam logic [ModeW-1:0] MODE_DATA  = 2'd0;
  localparam logic [ModeW-1:0] MODE_FLUSH = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLOSE = 2'd2;

  // register index as seen on paddr[2]
  localparam logic REG_CHUNK_TOTAL = 1'b0;

  localparam logic [DataW-1:0] CHAR_CR      = 8'h0d;
  localparam logic [DataW-1:0] CHAR_LF      = 8'h0a;
  localparam logic [DataW-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [DataW-1:0] CHAR_LOWER_A = 8'h61;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEX_HI,
    ST_HEX_LO,
    ST_CR1,
    ST_LF1,
    ST_DATA_RD,
    ST_DATA_WR,
    ST_CR2,
    ST_LF2,
    ST_FIN_0,
    ST_FIN_CR1,
    ST_FIN_LF1,
    ST_FIN_CR2,
    ST_FIN_LF2,
    ST_REJ
  } hce_state_e;

  function automatic logic [DataW-1:0] hex_char(input logic [3:0] d);
    logic [DataW-1:0] d8;
    d8 = {4'h0, d & HexMask};
    if (d8 < 8'd10) begin
      return CHAR_ZERO + d8;
    end
    return CHAR_LOWER_A - 8'd10 + d8;
  endfunction

endpackage

FILE: rtl/hce_stream_if.sv
interface hce_in_if
  import hce_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [DataW-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface hce_out_if
  import hce_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] out_byte;
  logic             is_last;
  logic             rejected;

  modport source (output valid, output out_byte, output is_last, output rejected,
                  input ready);
  modport sink   (input valid, input out_byte, input is_last, input rejected,
                  output ready);
endinterface

FILE: rtl/http_chunked_encoder_unit.sv
// Chunked transfer encoder.
// Requests arrive on req_i: mode selects data byte, flush or close. Encoded
// bytes leave on res_o, one per transfer, is_last marking the final byte a
// request causes. A data byte after close gives a single byte with rejected
// set. chunk_total_length must be written through the APB port only while
// idle; the block itself does not enforce this. A data byte that does not
// complete a chunk is taken and causes nothing. A chunk of N buffered bytes
// gives 1 or 2 hex digits, CRLF, the N data bytes and the closing CRLF; a
// close adds the final chunk. The buffer RAM has a registered read: each
// data byte is addressed in ST_DATA_RD and moved to the output in ST_DATA_WR.
// One request is sequenced at a time; req_i.ready is high only while idle,
// though a finished byte may still sit in the output register.
// A stalled receiver holds the output register and freezes the sequencer in
// its emitting states. Reset empties the buffer count, reopens the stream and
// loads 38 into chunk_total_length; the buffer RAM itself is not cleared,
// since only entries below the fill count are ever read.
module http_chunked_encoder_unit
  import hce_pkg::*;
#(
  parameter int unsigned MAX_CHUNK_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hce_in_if.sink              req_i,
  hce_out_if.source           res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AddrW = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
  localparam int unsigned FillW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam logic [6:0] MaxBytes = 7'(MAX_CHUNK_BYTES);

  hce_state_e state_q, state_d;

  logic [TotalW-1:0] total_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  size_q, size_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              closed_q, closed_d;
  logic              closing_q, closing_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_rej_q, out_rej_d;

  logic             load_ok;
  logic             req_fire;
  logic             ram_we;
  logic [DataW-1:0] ram_rdata;
  logic [6:0]       data_len;
  logic [6:0]       fill_inc;
  logic [7:0]       size8;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHUNK_TOTAL) ? ApbDataW'(total_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK_TOTAL) begin
      total_q <= pwdata[TotalW-1:0];
    end
  end

  // chunk data length: total less header (4 + hex digits of total-4), clamped
  always_comb begin
    logic [2:0] hdr;
    logic [6:0] t7;
    t7  = 7'(total_q);
    hdr = HdrBase;
    if (t7 > 7'(HdrBase)) begin
      hdr = ((t7 - 7'(HdrBase)) >= 7'd16) ? HdrBase + 3'd2 : HdrBase + 3'd1;
    end
    data_len = (t7 > 7'(hdr)) ? t7 - 7'(hdr) : 7'd0;
    if (data_len < 7'd1) begin
      data_len = 7'd1;
    end
    if (data_len > MaxBytes) begin
      data_len = MaxBytes;
    end
  end

  // ---------------------------------------------------------------- buffer
  assign req_fire = req_i.valid && req_i.ready;
  assign fill_inc = 7'(fill_q) + 7'd1;
  assign ram_we   = req_fire && req_i.mode == MODE_DATA && !closed_q &&
                    7'(fill_q) < MaxBytes;

  // each entry is written at accept and read only after the header bytes
  hce_ram #(
    .Width(DataW),
    .Depth(MAX_CHUNK_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (req_i.data_byte),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  assign req_i.ready = (state_q == ST_IDLE);
  assign load_ok     = !out_valid_q || res_o.ready;
  assign size8       = 8'(size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic [6:0] new_fill;
    logic       emit;
    logic [DataW-1:0] nb;
    logic             nl;
    logic             nr;

    state_d   = state_q;
    fill_d    = fill_q;
    size_d    = size_q;
    idx_d     = idx_q;
    closed_d  = closed_q;
    closing_d = closing_q;
    new_fill  = ram_we ? fill_inc : 7'(fill_q);
    emit      = 1'b0;
    nb        = '0;
    nl        = 1'b0;
    nr        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.mode)
            MODE_DATA: begin
              if (closed_q) begin
                state_d = ST_REJ;
              end else if (new_fill >= data_len) begin
                size_d    = FillW'(new_fill);
                fill_d    = '0;
                idx_d     = '0;
                closing_d = 1'b0;
                state_d   = (new_fill >= 7'd16) ? ST_HEX_HI : ST_HEX_LO;
              end else begin
                fill_d = FillW'(new_fill);
              end
            end
            MODE_FLUSH: begin
              if (!closed_q && fill_q != '0) begin
                size_d    = fill_q;
                fill_d    = '0;
                idx_d     = '0;
                closing_d = 1'b0;
                state_d   = (7'(fill_q) >= 7'd16) ? ST_HEX_HI : ST_HEX_LO;
              end
            end
            MODE_CLOSE: begin
              if (!closed_q) begin
                closed_d = 1'b1;
                if (fill_q != '0) begin
                  size_d    = fill_q;
                  fill_d    = '0;
                  idx_d     = '0;
                  closing_d = 1'b1;
                  state_d   = (7'(fill_q) >= 7'd16) ? ST_HEX_HI : ST_HEX_LO;
                end else begin
                  state_d = ST_FIN_0;
                end
              end
            end
            default: begin
              // unused mode: drop
            end
          endcase
        end
      end
      ST_HEX_HI: begin
        if (load_ok) begin
          emit = 1'b1; nb = hex_char(size8[7:4]); state_d = ST_HEX_LO;
        end
      end
      ST_HEX_LO: begin
        if (load_ok) begin
          emit = 1'b1; nb = hex_char(size8[3:0]); state_d = ST_CR1;
        end
      end
      ST_CR1: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_CR; state_d = ST_LF1;
        end
      end
      ST_LF1: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_LF; state_d = ST_DATA_RD;
        end
      end
      ST_DATA_RD: begin
        // address presented; data lands next cycle
        state_d = ST_DATA_WR;
      end
      ST_DATA_WR: begin
        if (load_ok) begin
          emit = 1'b1;
          nb   = ram_rdata;
          if (7'(idx_q) + 7'd1 == 7'(size_q)) begin
            idx_d   = '0;
            state_d = ST_CR2;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DATA_RD;
          end
        end
      end
      ST_CR2: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_CR; state_d = ST_LF2;
        end
      end
      ST_LF2: begin
        if (load_ok) begin
          emit    = 1'b1;
          nb      = CHAR_LF;
          nl      = !closing_q;
          state_d = closing_q ? ST_FIN_0 : ST_IDLE;
        end
      end
      ST_FIN_0: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_ZERO; state_d = ST_FIN_CR1;
        end
      end
      ST_FIN_CR1: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_CR; state_d = ST_FIN_LF1;
        end
      end
      ST_FIN_LF1: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_LF; state_d = ST_FIN_CR2;
        end
      end
      ST_FIN_CR2: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_CR; state_d = ST_FIN_LF2;
        end
      end
      ST_FIN_LF2: begin
        if (load_ok) begin
          emit = 1'b1; nb = CHAR_LF; nl = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (load_ok) begin
          emit = 1'b1; nl = 1'b1; nr = 1'b1; state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output register: load on emit, release once taken
    out_valid_d = out_valid_q && !res_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_rej_d   = out_rej_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = nb;
      out_last_d  = nl;
      out_rej_d   = nr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      closed_q    <= 1'b0;
      closing_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      closed_q    <= closed_d;
      closing_q   <= closing_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_rej_q  <= out_rej_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.is_last  = out_last_q;
  assign res_o.rejected = out_rej_q;

  // ---------------------------------------------------------------- checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    7'(fill_q) <= MaxBytes)
    else $error("fill count beyond buffer depth");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("stream reopened without reset");

  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (closed_q && state_q == ST_IDLE) |-> fill_q == '0)
    else $error("bytes buffered after close");

  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.rejected) |-> res_o.is_last)
    else $error("rejection not marked last");

endmodule

FILE: rtl/hce_ram.sv
module hce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
